// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the placer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== hdl/ffjp_pkg.sv =====
// Types and codes of the first-fit job placer.
`timescale 1ns / 1ps
`default_nettype none
package ffjp_pkg;
    localparam int NEED_W = 14;

    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_JOB   = 2'd2;
    localparam logic [1:0] CMD_SLOT  = 2'd3;

    typedef enum logic [2:0] {
        MODE_SPREAD = 3'b001,
        MODE_SINGLE = 3'b010,
        MODE_MULTI  = 3'b100
    } t_mode;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  node_sel;
        logic [9:0]  node_capacity;
        logic [9:0]  node_free;
        logic [15:0] job_id;
        logic [4:0]  nodes_needed;
        logic [13:0] procs_needed;
        logic        slot_last;
    } t_in_item;

    typedef struct packed {
        logic [15:0] job_id_out;
        logic [3:0]  assigned_node;
        logic [9:0]  assigned_procs;
        logic        failed;
        logic [15:0] task_count;
        logic        last_record;
    } t_out_item;
endpackage
`default_nettype wire

// ===== hdl/ffjp_node_tbl.sv =====
// Node table: capacity and free count per node, one write and one registered read.
`timescale 1ns / 1ps
`default_nettype none
module ffjp_node_tbl #(
    parameter int NODE_COUNT = 16,
    parameter int PROC_BITS  = 10,
    parameter int ADDR_BITS  = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [PROC_BITS-1:0] i_wcap,
    input  logic [PROC_BITS-1:0] i_wfree,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [PROC_BITS-1:0] o_rcap,
    output logic [PROC_BITS-1:0] o_rfree
);
    logic [2*PROC_BITS-1:0] mem [NODE_COUNT];
    logic [NODE_COUNT-1:0]  r_valid;
    logic [2*PROC_BITS-1:0] r_rd;
    logic                   r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wcap, i_wfree};
        end
        r_rd <= mem[i_raddr];
    end

    // entries never loaded read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rd_ok <= r_valid[i_raddr];
        end
    end

    assign o_rcap  = r_rd_ok ? r_rd[2*PROC_BITS-1:PROC_BITS] : '0;
    assign o_rfree = r_rd_ok ? r_rd[PROC_BITS-1:0] : '0;
endmodule
`default_nettype wire

// ===== hdl/fifo_first_fit_job_placer_top.sv =====
// Top level of the first-fit job placer.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Takes node loads and jobs one word at a time and places each job on the node
// table in arrival order. Node loads, pass starts and slot words that are not
// the last of a list are taken in the idle state. The table has one read port
// and is walked one node at a time, a read state then an evaluate state per
// node: a spread job sums the capacities of all nodes, then scans for free
// processors; a single-node job scans for one node that fits; a multi-node job
// reads each slot's need, then scans for a node per slot. Commit then walks the
// table once, skipping unused nodes and giving each used node a write-back and
// a record, stalling on the result side. The next word is taken once the
// job has left commit; the last record may still wait in the output register.
module fifo_first_fit_job_placer_top #(
    parameter int NODE_COUNT = 16,
    parameter int MAX_SLOTS  = 16,
    parameter int PROC_BITS  = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ffjp_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ffjp_pkg::t_out_item  o_out_data
);
    import ffjp_pkg::*;

    localparam int NB   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int SB   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int FW   = $clog2(MAX_SLOTS + 1);
    localparam int PW   = PROC_BITS;
    localparam int ACCW = PW + NB + 1;
    localparam int CW   = (ACCW > NEED_W) ? ACCW : NEED_W;
    localparam logic [NB-1:0] LAST_NODE = NB'(NODE_COUNT - 1);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_SUM_RD  = 10'b0000000010,
        S_SUM_EV  = 10'b0000000100,
        S_SLOT_RD = 10'b0000001000,
        S_SLOT_EV = 10'b0000010000,
        S_SCAN_RD = 10'b0000100000,
        S_SCAN_EV = 10'b0001000000,
        S_FAIL    = 10'b0010000000,
        S_COM_RD  = 10'b0100000000,
        S_COM_EV  = 10'b1000000000
    } t_state;

    t_state                r_state;
    logic                  r_halted;
    logic [15:0]           r_jobs;
    logic [FW-1:0]         r_fill;
    logic [NEED_W-1:0]     r_slot0;
    logic [15:0]           r_job;
    t_mode                 r_mode;
    logic [4:0]            r_nn;
    logic [NEED_W-1:0]     r_need;
    logic                  r_uniform;
    logic [FW-1:0]         r_filled;
    logic [4:0]            r_slot;
    logic [NEED_W-1:0]     r_ns;
    logic [NEED_W-1:0]     r_rem;
    logic [ACCW-1:0]       r_acc;
    logic                  r_fits;
    logic [NB-1:0]         r_n;
    logic [NODE_COUNT-1:0] r_used;
    logic [PW-1:0]         r_amt [NODE_COUNT];
    logic [NB-1:0]         r_last_node;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [NEED_W-1:0] slot_mem [MAX_SLOTS];
    logic [NEED_W-1:0] r_slot_rd;

    logic              in_acc;
    logic              can_load;
    logic              out_load;
    logic [PW-1:0]     tbl_cap;
    logic [PW-1:0]     tbl_free;
    logic              tbl_we;
    logic [NB-1:0]     tbl_waddr;
    logic [PW-1:0]     tbl_wcap;
    logic [PW-1:0]     tbl_wfree;
    logic [PW-1:0]     ld_cap;
    logic [PW-1:0]     ld_free;
    logic [FW-1:0]     n_filled;
    logic [NEED_W-1:0] need0;
    logic              st_go;
    logic [NEED_W-1:0] st_need;
    logic              st_uni;
    logic              fit_cap;
    logic              fit_free;
    logic              fits_now;
    logic [PW-1:0]     spread_amt;
    logic [NEED_W-1:0] rem_next;
    logic [ACCW-1:0]   acc_next;
    logic              slot_done;
    logic              mark_last;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign can_load    = !r_out_valid || i_out_ready;
    assign out_load    = can_load && (r_state == S_FAIL || r_state == S_COM_EV);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        ld_cap  = PW'(i_in_data.node_capacity);
        ld_free = PW'(i_in_data.node_free);
        if (ld_cap < ld_free) begin
            ld_free = ld_cap;
        end
        tbl_we    = 1'b0;
        tbl_waddr = NB'(i_in_data.node_sel);
        tbl_wcap  = ld_cap;
        tbl_wfree = ld_free;
        if (r_state == S_COM_EV) begin
            tbl_we    = can_load;
            tbl_waddr = r_n;
            tbl_wcap  = tbl_cap;
            tbl_wfree = tbl_free - r_amt[r_n];
        end else if (in_acc && i_in_data.command == CMD_LOAD
                     && int'(i_in_data.node_sel) < NODE_COUNT) begin
            tbl_we = 1'b1;
        end
    end

    ffjp_node_tbl #(
        .NODE_COUNT (NODE_COUNT),
        .PROC_BITS  (PW),
        .ADDR_BITS  (NB)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wcap  (tbl_wcap),
        .i_wfree (tbl_wfree),
        .i_raddr (r_n),
        .o_rcap  (tbl_cap),
        .o_rfree (tbl_free)
    );

    // slot list buffer
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.command == CMD_SLOT && r_fill < FW'(MAX_SLOTS)) begin
            slot_mem[SB'(r_fill)] <= i_in_data.procs_needed;
        end
        r_slot_rd <= slot_mem[SB'(r_slot)];
    end

    always_comb begin
        n_filled = (r_fill < FW'(MAX_SLOTS)) ? r_fill + FW'(1) : r_fill;
        need0    = (r_fill == '0) ? i_in_data.procs_needed : r_slot0;
        st_go    = in_acc && !r_halted && ((i_in_data.command == CMD_JOB)
                   || (i_in_data.command == CMD_SLOT && i_in_data.slot_last));
        st_need  = (i_in_data.command == CMD_JOB) ? i_in_data.procs_needed : need0;
        st_uni   = (i_in_data.command == CMD_JOB) || (n_filled == FW'(1));

        fit_cap    = CW'(r_ns) <= CW'(tbl_cap);
        fit_free   = CW'(r_ns) <= CW'(tbl_free);
        fits_now   = r_fits || (!r_used[r_n] && fit_cap);
        spread_amt = (CW'(r_rem) < CW'(tbl_free)) ? PW'(r_rem) : tbl_free;
        rem_next   = r_rem - NEED_W'(spread_amt);
        acc_next   = r_acc + ACCW'(tbl_cap);
        slot_done  = (6'(r_slot) + 6'd1) == 6'(r_nn);
        mark_last  = (r_used == '0) || (r_n > r_last_node);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_halted    <= 1'b0;
            r_jobs      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in_data.command == CMD_BEGIN) begin
                        r_halted <= 1'b0;
                        r_jobs   <= '0;
                        r_fill   <= '0;
                    end
                    if (in_acc && i_in_data.command == CMD_SLOT) begin
                        if (r_fill == '0) begin
                            r_slot0 <= i_in_data.procs_needed;
                        end
                        r_fill <= i_in_data.slot_last ? '0 : n_filled;
                    end
                    if (st_go) begin
                        r_job     <= i_in_data.job_id;
                        r_nn      <= i_in_data.nodes_needed;
                        r_need    <= st_need;
                        r_ns      <= st_need;
                        r_rem     <= st_need;
                        r_uniform <= st_uni;
                        r_filled  <= n_filled;
                        r_used    <= '0;
                        r_n       <= '0;
                        r_acc     <= '0;
                        r_fits    <= 1'b0;
                        r_slot    <= '0;
                        r_last_node <= '0;
                        if (i_in_data.nodes_needed == 5'd0) begin
                            r_mode  <= MODE_SPREAD;
                            r_state <= S_SUM_RD;
                        end else if (i_in_data.nodes_needed == 5'd1) begin
                            r_mode  <= MODE_SINGLE;
                            r_state <= S_SCAN_RD;
                        end else begin
                            r_mode  <= MODE_MULTI;
                            r_state <= S_SLOT_RD;
                        end
                    end
                end
                S_SUM_RD: r_state <= S_SUM_EV;
                S_SUM_EV: begin
                    r_acc <= acc_next;
                    if (r_n == LAST_NODE) begin
                        r_n <= '0;
                        if (CW'(r_need) > CW'(acc_next)) begin
                            r_state <= S_FAIL;
                        end else if (r_need == '0) begin
                            r_jobs  <= r_jobs + 16'd1;
                            r_state <= S_COM_RD;
                        end else begin
                            r_state <= S_SCAN_RD;
                        end
                    end else begin
                        r_n     <= r_n + NB'(1);
                        r_state <= S_SUM_RD;
                    end
                end
                S_SLOT_RD: r_state <= S_SLOT_EV;
                S_SLOT_EV: begin
                    if (r_uniform) begin
                        r_ns <= r_need;
                    end else if (int'(r_slot) < int'(r_filled)) begin
                        r_ns <= r_slot_rd;
                    end else begin
                        r_ns <= '0;
                    end
                    r_fits  <= 1'b0;
                    r_n     <= '0;
                    r_state <= S_SCAN_RD;
                end
                S_SCAN_RD: r_state <= S_SCAN_EV;
                S_SCAN_EV: begin
                    if (r_mode == MODE_SPREAD) begin
                        if (tbl_free != '0) begin
                            r_used[r_n] <= 1'b1;
                            r_amt[r_n]  <= spread_amt;
                            r_rem       <= rem_next;
                            if (mark_last) begin
                                r_last_node <= r_n;
                            end
                        end
                        if (tbl_free != '0 && rem_next == '0) begin
                            r_jobs  <= r_jobs + 16'd1;
                            r_n     <= '0;
                            r_state <= S_COM_RD;
                        end else if (r_n == LAST_NODE) begin
                            r_halted <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_n     <= r_n + NB'(1);
                            r_state <= S_SCAN_RD;
                        end
                    end else begin
                        if (!r_used[r_n] && fit_free) begin
                            r_used[r_n] <= 1'b1;
                            r_amt[r_n]  <= PW'(r_ns);
                            if (mark_last) begin
                                r_last_node <= r_n;
                            end
                            if (r_mode == MODE_SINGLE || slot_done) begin
                                r_jobs  <= r_jobs + 16'd1;
                                r_n     <= '0;
                                r_state <= S_COM_RD;
                            end else begin
                                r_slot  <= r_slot + 5'd1;
                                r_state <= S_SLOT_RD;
                            end
                        end else if (r_n == LAST_NODE) begin
                            if (fits_now) begin
                                r_halted <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_state <= S_FAIL;
                            end
                        end else begin
                            r_fits  <= fits_now;
                            r_n     <= r_n + NB'(1);
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_FAIL: begin
                    if (can_load) begin
                        r_jobs      <= r_jobs + 16'd1;
                        r_out.job_id_out     <= r_job;
                        r_out.assigned_node  <= '0;
                        r_out.assigned_procs <= '0;
                        r_out.failed         <= 1'b1;
                        r_out.task_count     <= r_jobs + 16'd1;
                        r_out.last_record    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_COM_RD: begin
                    if (r_used[r_n]) begin
                        r_state <= S_COM_EV;
                    end else if (r_n == LAST_NODE) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_n <= r_n + NB'(1);
                    end
                end
                S_COM_EV: begin
                    // free count write-back happens on the same edge
                    if (can_load) begin
                        r_out.job_id_out     <= r_job;
                        r_out.assigned_node  <= 4'(r_n);
                        r_out.assigned_procs <= 10'(r_amt[r_n]);
                        r_out.failed         <= 1'b0;
                        r_out.task_count     <= r_jobs;
                        r_out.last_record    <= (r_n == r_last_node);
                        if (r_n == r_last_node || r_n == LAST_NODE) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_n     <= r_n + NB'(1);
                            r_state <= S_COM_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEVER(a_fail_shape, i_clk, i_rst_n, o_out_valid && o_out_data.failed && !o_out_data.last_record, "fail word not final")
    `ASSERT_CHK(a_commit_used, i_clk, i_rst_n, r_state == S_COM_EV |-> r_used[r_n], "commit on unplanned node")
    `ASSERT_CHK(a_halt_idle, i_clk, i_rst_n, r_halted |-> r_state == S_IDLE, "job started in halted pass")
    `ASSERT_CHK(a_rem_bound, i_clk, i_rst_n, r_state == S_SCAN_EV && r_mode == MODE_SPREAD |-> r_rem <= r_need, "spread remainder grew")
endmodule
`default_nettype wire

// ===== tb/tb_fifo_first_fit_job_placer_top.sv =====
// Self-checking testbench of the first-fit job placer top level.
`timescale 1ns / 1ps
`default_nettype none
module tb_fifo_first_fit_job_placer_top;
    import ffjp_pkg::*;

    localparam int NODES     = 16;
    localparam int SLOTS_MAX = 16;
    localparam int CYC_LIMIT = 1500000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    fifo_first_fit_job_placer_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    // predictor state
    logic [9:0]  cap_tbl [NODES];
    logic [9:0]  free_tbl [NODES];
    logic [13:0] slot_need [SLOTS_MAX];
    int unsigned slot_cnt;
    bit          halted;
    logic [15:0] placed_cnt;
    bit          pl_used [NODES];
    logic [9:0]  pl_amt [NODES];

    t_in_item  word_q [$];
    t_out_item record_q [$];
    int        errors;
    int        cycles;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_off;

    function automatic void add_word(t_in_item w);
        word_q = {word_q, w};
    endfunction

    function automatic void add_record(t_out_item r);
        record_q = {record_q, r};
    endfunction

    function automatic void clear_plan();
        for (int n = 0; n < NODES; n++) begin
            pl_used[n] = 0;
            pl_amt[n]  = '0;
        end
    endfunction

    function automatic void push_fail(logic [15:0] job);
        t_out_item r;
        placed_cnt = placed_cnt + 16'd1;
        r = '{job_id_out: job, assigned_node: '0, assigned_procs: '0, failed: 1'b1,
              task_count: placed_cnt, last_record: 1'b1};
        add_record(r);
    endfunction

    function automatic void commit_job(logic [15:0] job);
        t_out_item r;
        int first = record_q.size();
        placed_cnt = placed_cnt + 16'd1;
        for (int n = 0; n < NODES; n++) begin
            if (pl_used[n]) begin
                free_tbl[n] = free_tbl[n] - pl_amt[n];
                r = '{job_id_out: job, assigned_node: n[3:0], assigned_procs: pl_amt[n],
                      failed: 1'b0, task_count: placed_cnt, last_record: 1'b0};
                add_record(r);
            end
        end
        if (record_q.size() > first) record_q[$].last_record = 1'b1;
    endfunction

    function automatic void place_job(logic [15:0] job, int unsigned nn, int unsigned need,
                                      bit uniform, int unsigned filled);
        int unsigned total;
        int unsigned rem;
        int unsigned ns;
        bit fits;
        bit found;
        if (halted) return;
        clear_plan();
        if (nn == 0) begin
            total = 0;
            for (int n = 0; n < NODES; n++) total += cap_tbl[n];
            if (need > total) begin
                push_fail(job);
                return;
            end
            rem = need;
            for (int n = 0; n < NODES && rem > 0; n++) begin
                if (free_tbl[n] == 0) continue;
                pl_used[n] = 1;
                pl_amt[n]  = (rem < free_tbl[n]) ? rem[9:0] : free_tbl[n];
                rem -= pl_amt[n];
            end
            if (rem > 0) halted = 1;
            else commit_job(job);
        end else if (nn == 1) begin
            fits = 0;
            for (int n = 0; n < NODES; n++) begin
                if (need <= cap_tbl[n]) fits = 1;
                if (need <= free_tbl[n]) begin
                    pl_used[n] = 1;
                    pl_amt[n]  = need[9:0];
                    commit_job(job);
                    return;
                end
            end
            if (!fits) push_fail(job);
            else halted = 1;
        end else begin
            for (int unsigned s = 0; s < nn; s++) begin
                ns = uniform ? need : ((s < filled && s < SLOTS_MAX) ? slot_need[s] : 0);
                fits  = 0;
                found = 0;
                for (int n = 0; n < NODES; n++) begin
                    if (pl_used[n]) continue;
                    if (ns <= cap_tbl[n]) fits = 1;
                    if (ns <= free_tbl[n]) begin
                        pl_used[n] = 1;
                        pl_amt[n]  = ns[9:0];
                        found = 1;
                        break;
                    end
                end
                if (!fits) begin
                    push_fail(job);
                    return;
                end
                if (!found) begin
                    halted = 1;
                    return;
                end
            end
            commit_job(job);
        end
    endfunction

    function automatic void predict_word(t_in_item w);
        int unsigned filled;
        case (w.command)
            CMD_BEGIN: begin
                halted     = 0;
                placed_cnt = '0;
                slot_cnt   = 0;
            end
            CMD_LOAD: begin
                cap_tbl[w.node_sel]  = w.node_capacity;
                free_tbl[w.node_sel] = (w.node_free < w.node_capacity) ?
                                       w.node_free : w.node_capacity;
            end
            CMD_JOB: place_job(w.job_id, w.nodes_needed, w.procs_needed, 1, 0);
            default: begin
                if (slot_cnt < SLOTS_MAX) begin
                    slot_need[slot_cnt] = w.procs_needed;
                    slot_cnt++;
                end
                if (w.slot_last) begin
                    filled   = slot_cnt;
                    slot_cnt = 0;
                    place_job(w.job_id, w.nodes_needed, slot_need[0], filled == 1, filled);
                end
            end
        endcase
    endfunction

    function automatic t_in_item rand_word();
        t_in_item w;
        w = '{command: 2'($urandom_range(0, 3)), node_sel: 4'($urandom),
              node_capacity: 10'($urandom), node_free: 10'($urandom),
              job_id: 16'($urandom), nodes_needed: 5'($urandom_range(0, 31)),
              procs_needed: 14'($urandom), slot_last: 1'($urandom)};
        return w;
    endfunction

    function automatic t_in_item load_word(int idx, int cap, int fr);
        t_in_item w = rand_word();
        w.command = CMD_LOAD;
        w.node_sel = idx[3:0];
        w.node_capacity = cap[9:0];
        w.node_free = fr[9:0];
        return w;
    endfunction

    function automatic t_in_item job_word(int cmd, int nn, int need, bit last);
        t_in_item w = rand_word();
        w.command = cmd[1:0];
        w.nodes_needed = nn[4:0];
        w.procs_needed = need[13:0];
        w.slot_last = last;
        return w;
    endfunction

    // a pass start and loads of a random subset of nodes, then 2 to 6 jobs or random words
    task automatic queue_random_pass();
        int nj;
        int nn;
        int ns;
        int big;
        t_in_item w;
        add_word(job_word(CMD_BEGIN, 0, 0, 0));
        big = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < NODES; n++) begin
            if ($urandom_range(0, 2) != 0) begin
                w = load_word(n, big ? $urandom_range(0, 1023) : $urandom_range(0, 40),
                              big ? $urandom_range(0, 1023) : $urandom_range(0, 45));
                add_word(w);
            end
        end
        nj = $urandom_range(2, 6);
        for (int j = 0; j < nj; j++) begin
            case ($urandom_range(0, 9))
                0: add_word(rand_word());
                1, 2, 3: begin
                    nn = $urandom_range(0, 5);
                    add_word(job_word(CMD_JOB, nn, $urandom_range(0, 60), 0));
                end
                4: add_word(job_word(CMD_JOB, $urandom_range(0, 17),
                                     $urandom_range(0, 16383), 0));
                default: begin
                    nn = $urandom_range(0, 18);
                    ns = $urandom_range(1, 18);
                    for (int s = 0; s < ns; s++)
                        add_word(job_word(CMD_SLOT, nn, $urandom_range(0, 50),
                                          s == ns - 1));
                end
            endcase
        end
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycles <= cycles + 1;

    always @(posedge i_clk) begin
        if (cycles >= CYC_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) predict_word(i_in_data);
            if (word_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_data  <= word_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (record_q.size() == 0) begin
                    $error("record with no expectation: %p", o_out_data);
                    errors = errors + 1;
                end else begin
                    exp_r = record_q.pop_front();
                    if (o_out_data.job_id_out !== exp_r.job_id_out) begin
                        $error("job_id_out exp %0d got %0d", exp_r.job_id_out,
                               o_out_data.job_id_out);
                        errors = errors + 1;
                    end
                    if (o_out_data.assigned_node !== exp_r.assigned_node) begin
                        $error("assigned_node exp %0d got %0d", exp_r.assigned_node,
                               o_out_data.assigned_node);
                        errors = errors + 1;
                    end
                    if (o_out_data.assigned_procs !== exp_r.assigned_procs) begin
                        $error("assigned_procs exp %0d got %0d", exp_r.assigned_procs,
                               o_out_data.assigned_procs);
                        errors = errors + 1;
                    end
                    if (o_out_data.failed !== exp_r.failed) begin
                        $error("failed exp %0d got %0d", exp_r.failed, o_out_data.failed);
                        errors = errors + 1;
                    end
                    if (o_out_data.task_count !== exp_r.task_count) begin
                        $error("task_count exp %0d got %0d", exp_r.task_count,
                               o_out_data.task_count);
                        errors = errors + 1;
                    end
                    if (o_out_data.last_record !== exp_r.last_record) begin
                        $error("last_record exp %0d got %0d", exp_r.last_record,
                               o_out_data.last_record);
                        errors = errors + 1;
                    end
                end
            end
        end
    end

    // receiver; a hold-off counts down in here
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off    <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic wait_drained();
        while (word_q.size() > 0 || i_in_valid) @(posedge i_clk);
        while (record_q.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        int phase;
        cycles = 0;
        errors = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        slot_cnt = 0;
        halted = 0;
        placed_cnt = '0;
        for (int n = 0; n < NODES; n++) begin
            cap_tbl[n]  = '0;
            free_tbl[n] = '0;
        end
        for (int s = 0; s < SLOTS_MAX; s++) slot_need[s] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: spread fail on an empty table, loads at the extremes, each mode
        add_word(job_word(CMD_JOB, 0, 1, 0));
        add_word(job_word(CMD_JOB, 0, 0, 0));
        add_word(load_word(0, 1023, 1023));
        add_word(load_word(15, 1023, 0));
        add_word(load_word(3, 5, 900));
        add_word(load_word(7, 0, 0));
        add_word(job_word(CMD_JOB, 1, 16383, 0));
        add_word(job_word(CMD_JOB, 1, 4, 0));
        add_word(job_word(CMD_JOB, 16, 0, 0));
        add_word(job_word(CMD_SLOT, 3, 10, 0));
        add_word(job_word(CMD_SLOT, 3, 2, 1));
        add_word(job_word(CMD_SLOT, 2, 7, 1));
        add_word(job_word(CMD_JOB, 0, 2000, 0));
        add_word(job_word(CMD_JOB, 1, 1, 0));
        add_word(job_word(CMD_BEGIN, 0, 0, 0));
        for (int s = 0; s < 18; s++)
            add_word(job_word(CMD_SLOT, 31, 0, s == 17));
        add_word(job_word(CMD_JOB, 0, 1023, 0));
        add_word(job_word(CMD_JOB, 1, 1023, 0));
        add_word(job_word(CMD_JOB, 0, 1, 0));
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        for (int p = 0; p < 2; p++) queue_random_pass();
        add_word(load_word(1, 1023, 1023));
        for (int j = 0; j < 8; j++) add_word(job_word(CMD_JOB, 16, 1, 0));
        hold_off <= 3000;
        wait_drained();

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1 || phase == 3) ? (phase == 1 ? 55 : 35) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 55 : 35) : 0;
            for (int p = 0; p < 2; p++) queue_random_pass();
            wait_drained();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (200) @(posedge i_clk);
        if (errors == 0 && record_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (record_q.size() > 0) $error("%0d records never arrived", record_q.size());
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/ffjp_pkg.sv
hdl/ffjp_node_tbl.sv
hdl/fifo_first_fit_job_placer_top.sv
tb/tb_fifo_first_fit_job_placer_top.sv
